@@ rtl/sspd_pkg.sv @@
`timescale 1ns / 1ps

package sspd_pkg;

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] STX_CODE = 8'h02;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int TDATA_W = 40;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] packet_length;
        logic       checksum_ok;
        logic [7:0] computed_sum;
    } sspd_result_t;

endpackage

@@ rtl/soh_stx_packet_deframer.sv @@
`timescale 1ns / 1ps
// SOH/STX length-prefixed packet deframer with additive checksum.
// A result beat passes the input register, then the result register, before it shows on m_*; m_tready can stall it.
// Throughput: one byte per cycle unless m_tready stalls; input register, parser, result register.
// Reset: rst_n asynchronous active low; parser returns to hunting, pipe empties.

module soh_stx_packet_deframer
    import sspd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // [7:0] data_byte, [15:8] byte_index,
                                         // [23:16] packet_length, [24] checksum_ok,
                                         // [32:25] computed_sum, rest zero
    output logic               m_tuser   // [0] result_kind
);

    logic         byte_valid;
    logic [7:0]   rx_byte;
    logic         advance;
    sspd_result_t res;
    sspd_result_t out_reg;
    logic         out_valid_reg, out_valid_next;

    assign advance = byte_valid && (!out_valid_reg || m_tready);

    sspd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    sspd_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (rx_byte),
        .res     (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.computed_sum, out_reg.checksum_ok,
                       out_reg.packet_length, out_reg.byte_index, out_reg.data_byte};

endmodule

@@ rtl/sspd_in_stage.sv @@
`timescale 1ns / 1ps

module sspd_in_stage
    import sspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

@@ rtl/sspd_parse.sv @@
`timescale 1ns / 1ps

module sspd_parse
    import sspd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    output sspd_result_t res
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_COUNT = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] taken_reg, taken_next;
    logic [7:0] sum_reg, sum_next;

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        res        = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (prev_reg == SOH_CODE && rx_byte == STX_CODE)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    prev_next = rx_byte;
                end
            end
            PH_COUNT:
            begin
                len_next   = rx_byte;
                taken_next = 8'd0;
                sum_next   = 8'd0;
                phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                res.valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.data_byte  = rx_byte;
                res.byte_index = taken_reg;
                sum_next       = sum_reg + rx_byte;
                taken_next     = taken_reg + 8'd1;
                if (taken_next == len_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                res.valid         = 1'b1;
                res.kind          = KIND_END;
                res.packet_length = len_reg;
                res.checksum_ok   = (rx_byte == sum_reg);
                res.computed_sum  = sum_reg;
                phase_next        = PH_HUNT;
                prev_next         = 8'd0;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= 8'd0;
            len_reg   <= 8'd0;
            taken_reg <= 8'd0;
            sum_reg   <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

@@ bench/soh_stx_packet_deframer_tb.sv @@
`timescale 1ns / 1ps

module soh_stx_packet_deframer_tb;
    import sspd_pkg::*;

    localparam int STALL_PCT      = 28;
    localparam int QUIET_FROM     = 900;
    localparam int QUIET_TO       = 1200;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_LEN       = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 1100;

    typedef enum logic [1:0] {
        SEEK_START,
        TAKE_COUNT,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } frame_phase_t;

    typedef struct {
        bit         hold;   // wait here until every result is back
        logic [7:0] value;
    } rx_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    rx_item_t     link_bytes[$];
    sspd_result_t owed_results[$];

    frame_phase_t frame_phase = SEEK_START;
    logic [7:0]   hunt_byte = 8'h00;
    logic [7:0]   frame_len = 8'h00;
    logic [7:0]   frame_taken = 8'h00;
    logic [7:0]   frame_sum = 8'h00;

    int cycle_count = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int mismatches = 0;
    int results_seen = 0;

    soh_stx_packet_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        if (mismatches < 100)
            $display("mismatch: %s at result %0d, got %0h, want %0h",
                     what, results_seen, got, want);
        mismatches++;
    endtask

    // Predictor: advances the framing state by one link byte.
    task automatic deframe_byte(input logic [7:0] b);
        sspd_result_t r;
        r = '0;
        r.valid = 1'b1;
        case (frame_phase)
            SEEK_START:
            begin
                if (hunt_byte == SOH_CODE && b == STX_CODE)
                    frame_phase = TAKE_COUNT;
                else
                    hunt_byte = b;
            end
            TAKE_COUNT:
            begin
                frame_len   = b;
                frame_taken = 8'h00;
                frame_sum   = 8'h00;
                frame_phase = (b == 8'h00) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD:
            begin
                r.kind       = KIND_DATA;
                r.data_byte  = b;
                r.byte_index = frame_taken;
                frame_sum    = frame_sum + b;
                frame_taken  = frame_taken + 8'h01;
                if (frame_taken == frame_len)
                    frame_phase = TAKE_CHECKSUM;
                owed_results.push_back(r);
            end
            default:
            begin
                r.kind          = KIND_END;
                r.packet_length = frame_len;
                r.checksum_ok   = (b == frame_sum);
                r.computed_sum  = frame_sum;
                frame_phase     = SEEK_START;
                hunt_byte       = 8'h00;
                owed_results.push_back(r);
            end
        endcase
    endtask

    task automatic check_beat(input sspd_result_t want);
        if (m_tuser !== want.kind)
            report_mismatch("result_kind", 40'(m_tuser), 40'(want.kind));
        if (m_tdata[7:0] !== want.data_byte)
            report_mismatch("data_byte", 40'(m_tdata[7:0]), 40'(want.data_byte));
        if (m_tdata[15:8] !== want.byte_index)
            report_mismatch("byte_index", 40'(m_tdata[15:8]), 40'(want.byte_index));
        if (m_tdata[23:16] !== want.packet_length)
            report_mismatch("packet_length", 40'(m_tdata[23:16]),
                            40'(want.packet_length));
        if (m_tdata[24] !== want.checksum_ok)
            report_mismatch("checksum_ok", 40'(m_tdata[24]), 40'(want.checksum_ok));
        if (m_tdata[32:25] !== want.computed_sum)
            report_mismatch("computed_sum", 40'(m_tdata[32:25]),
                            40'(want.computed_sum));
        if (m_tdata[TDATA_W-1:33] !== '0)
            report_mismatch("tdata padding", 40'(m_tdata[TDATA_W-1:33]), 40'd0);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_item_t it;
        it.hold  = 1'b0;
        it.value = b;
        link_bytes.push_back(it);
    endtask

    task automatic queue_hold();
        rx_item_t it;
        it.hold  = 1'b1;
        it.value = 8'h00;
        link_bytes.push_back(it);
    endtask

    function automatic logic [7:0] rand_byte();
        // lean on the framing codes so they show up inside payloads and noise
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 0) ? SOH_CODE : STX_CODE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_packet(input int len, input bit all_ones, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        queue_byte(SOH_CODE);
        queue_byte(STX_CODE);
        queue_byte(8'(len));
        for (int i = 0; i < len; i++)
        begin
            b = all_ones ? 8'hFF : rand_byte();
            sum = sum + b;
            queue_byte(b);
        end
        queue_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endtask

    // stimulus and end of run
    initial
    begin : stim_p
        logic [7:0] opening [0:25];
        int         sent;
        int         pick;
        int         len;

        opening = '{
            STX_CODE,                                           // STX right after reset
            SOH_CODE, SOH_CODE, STX_CODE, 8'h03, 8'hFF, 8'h00,  // repeated SOH
            8'h80, 8'h7F,
            SOH_CODE, STX_CODE, 8'h00, 8'h00,                   // empty payload
            SOH_CODE, STX_CODE, 8'h02, SOH_CODE, STX_CODE,      // start pair as data
            8'h04,                                              // bad checksum
            SOH_CODE, STX_CODE, 8'h01, SOH_CODE, SOH_CODE,      // checksum equals SOH
            STX_CODE, 8'h00                                     // STX after packet
        };
        foreach (opening[i])
            queue_byte(opening[i]);
        queue_hold();

        queue_packet(255, 1'b1, 1'b0);
        queue_packet(255, 1'b0, 1'b1);
        sent = 2 * (255 + 4);

        while (sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_byte(SOH_CODE);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60)
                                                   : $urandom_range(0, 8);
                queue_packet(len, 1'b0, $urandom_range(0, 99) < 15);
                sent += len + 4;
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(1, 4))
                    queue_byte(rand_byte());
            end
            else
            begin
                // near misses of the start pair
                queue_byte(SOH_CODE);
                queue_byte(rand_byte());
                queue_byte(STX_CODE);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (link_bytes.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
            report_mismatch("results never delivered", 40'(owed_results.size()), 40'd0);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            cycle_count <= cycle_count + 1;
    end

    // link byte driver
    always @(posedge clk)
    begin : drive_p
        logic       next_valid;
        logic [7:0] next_data;
        rx_item_t   it;
        bit         quiet;
        if (rst_n)
        begin
            quiet      = (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (!s_tvalid || s_tready)
            begin
                next_valid = 1'b0;
                if (link_bytes.size() != 0 && link_bytes[0].hold && !s_tvalid &&
                    owed_results.size() == 0)
                    void'(link_bytes.pop_front());
                if (link_bytes.size() != 0 && !link_bytes[0].hold &&
                    (quiet || $urandom_range(0, 99) >= STALL_PCT))
                begin
                    it         = link_bytes.pop_front();
                    next_valid = 1'b1;
                    next_data  = it.value;
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // result sink with one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cycle_count == HOLD_AT)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;

            if (cycle_count == HOLD_AT || hold_left > 1)
                m_tready <= 1'b0;
            else
                m_tready <= (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                            ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    // pop before push: a result never shares an edge with its own byte
    always @(posedge clk)
    begin : watch_p
        sspd_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected beat", {m_tuser, m_tdata[38:0]}, 40'd0);
                else
                begin
                    want = owed_results.pop_front();
                    check_beat(want);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
rtl/sspd_pkg.sv
rtl/sspd_in_stage.sv
rtl/sspd_parse.sv
rtl/soh_stx_packet_deframer.sv
bench/soh_stx_packet_deframer_tb.sv
